// File: src/uoip_pkg.sv
// Shared types, codes and helpers for the UTC offset parser.
`timescale 1ns / 1ps

package uoip_pkg;

    localparam int STORE_DEPTH = 9;
    localparam int CHAR_W      = 8;
    localparam int COUNT_W     = 4;
    localparam int LIMIT_W     = 17;
    localparam int SECONDS_W   = 18;
    localparam int TOTAL_W     = 19;
    localparam int STATUS_W    = 3;

    localparam logic [COUNT_W-1:0] COUNT_SAT = 4'd10;
    localparam logic [LIMIT_W-1:0] LIMIT_CAP = 17'd86399;
    localparam logic [LIMIT_W-1:0] LIMIT_RST = 17'd64800;

    localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FORMAT = 3'd1;
    localparam logic [STATUS_W-1:0] ST_SIGN   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_COLON  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DIGIT  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_RANGE  = 3'd5;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_Z     = 8'h5A;

    // One complete offset text, handed from the collector to the decoder.
    typedef struct packed {
        logic [STORE_DEPTH-1:0][CHAR_W-1:0] chars;
        logic [COUNT_W-1:0]                 len;
    } t_frame;

    function automatic logic f_is_digit(input logic [CHAR_W-1:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // Value of a two-digit field; only meaningful when both are digits.
    function automatic logic [6:0] f_field2(input logic [CHAR_W-1:0] a,
                                            input logic [CHAR_W-1:0] b);
        logic [6:0] hi;
        logic [6:0] lo;
        hi = {3'd0, a[3:0]};
        lo = {3'd0, b[3:0]};
        return 7'((hi << 3) + (hi << 1) + lo);
    endfunction

endpackage

// File: src/uoip_collect.sv
// Character store and counter that assemble one offset text into a frame.
`timescale 1ns / 1ps

module uoip_collect import uoip_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [CHAR_W-1:0] i_char,
    input  logic              i_last,
    input  logic              i_frame_take,
    output t_frame            o_frame,
    output logic              o_frame_valid
);

    logic [STORE_DEPTH-1:0][CHAR_W-1:0] r_store;
    logic [COUNT_W-1:0]                 r_count;
    logic [COUNT_W-1:0]                 n_count;
    t_frame                             r_frame;
    t_frame                             n_frame;
    logic                               r_frame_valid;

    always_comb begin
        n_count = (r_count < COUNT_SAT) ? r_count + 4'd1 : r_count;
        // The frame includes the character arriving with the last item.
        for (int i = 0; i < STORE_DEPTH; i++) begin
            n_frame.chars[i] = (r_count == COUNT_W'(i)) ? i_char : r_store[i];
        end
        n_frame.len = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && (r_count < COUNT_W'(STORE_DEPTH))) begin
            r_store[r_count] <= i_char;
        end
        if (i_accept && i_last) begin
            r_frame <= n_frame;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count       <= '0;
            r_frame_valid <= 1'b0;
        end else begin
            if (i_accept) begin
                r_count <= i_last ? '0 : n_count;
            end
            if (i_accept && i_last) begin
                r_frame_valid <= 1'b1;
            end else if (i_frame_take) begin
                r_frame_valid <= 1'b0;
            end
        end
    end

    assign o_frame       = r_frame;
    assign o_frame_valid = r_frame_valid;

endmodule

// File: src/uoip_decode.sv
// Field checks, total seconds and range test for one assembled offset text.
`timescale 1ns / 1ps

module uoip_decode import uoip_pkg::*; (
    input  t_frame                i_frame,
    input  logic [LIMIT_W-1:0]    i_limit,
    output logic [STATUS_W-1:0]   o_status,
    output logic [SECONDS_W-1:0]  o_seconds
);

    logic [STORE_DEPTH-1:0][CHAR_W-1:0] c;
    logic [STATUS_W-1:0]                err;
    logic                               ok_len;
    logic [6:0]                         h;
    logic [6:0]                         m;
    logic [6:0]                         s;
    logic                               d1;
    logic                               f1;
    logic                               f3;
    logic                               f4;
    logic                               f5;
    logic                               f7;
    logic [TOTAL_W-1:0]                 total;
    logic [LIMIT_W-1:0]                 limit;
    logic [SECONDS_W-1:0]               mag;

    always_comb begin
        c      = i_frame.chars;
        err    = ST_OK;
        ok_len = 1'b1;
        h      = '0;
        m      = '0;
        s      = '0;
        d1     = f_is_digit(c[1]);
        f1     = d1 && f_is_digit(c[2]);
        f3     = f_is_digit(c[3]) && f_is_digit(c[4]);
        f4     = f_is_digit(c[4]) && f_is_digit(c[5]);
        f5     = f_is_digit(c[5]) && f_is_digit(c[6]);
        f7     = f_is_digit(c[7]) && f_is_digit(c[8]);

        case (i_frame.len)
            4'd2: begin
                if (!d1) err = ST_DIGIT;
                else     h   = {3'd0, c[1][3:0]};
            end
            4'd3: begin
                if (!f1) err = ST_DIGIT;
                else     h   = f_field2(c[1], c[2]);
            end
            4'd5: begin
                if (!f1 || !f3) err = ST_DIGIT;
                h = f_field2(c[1], c[2]);
                m = f_field2(c[3], c[4]);
            end
            4'd6: begin
                if (!f1)                   err = ST_DIGIT;
                else if (c[3] != CH_COLON) err = ST_COLON;
                else if (!f4)              err = ST_DIGIT;
                h = f_field2(c[1], c[2]);
                m = f_field2(c[4], c[5]);
            end
            4'd7: begin
                if (!f1 || !f3 || !f5) err = ST_DIGIT;
                h = f_field2(c[1], c[2]);
                m = f_field2(c[3], c[4]);
                s = f_field2(c[5], c[6]);
            end
            4'd9: begin
                if (!f1)                   err = ST_DIGIT;
                else if (c[3] != CH_COLON) err = ST_COLON;
                else if (!f4)              err = ST_DIGIT;
                else if (c[6] != CH_COLON) err = ST_COLON;
                else if (!f7)              err = ST_DIGIT;
                h = f_field2(c[1], c[2]);
                m = f_field2(c[4], c[5]);
                s = f_field2(c[7], c[8]);
            end
            default: begin
                ok_len = 1'b0;
            end
        endcase

        if (err == ST_OK && !ok_len) begin
            err = ST_FORMAT;
        end
        if (err == ST_OK && c[0] != CH_PLUS && c[0] != CH_MINUS) begin
            err = ST_SIGN;
        end

        total = TOTAL_W'(h) * TOTAL_W'(3600) + TOTAL_W'(m) * TOTAL_W'(60) + TOTAL_W'(s);
        limit = (i_limit > LIMIT_CAP) ? LIMIT_CAP : i_limit;
        if (err == ST_OK && total > TOTAL_W'(limit)) begin
            err = ST_RANGE;
        end

        // The single-character text "Z" is valid on its own and means zero.
        if (i_frame.len == 4'd1 && c[0] == CH_Z) begin
            err = ST_OK;
            ok_len = 1'b1;
            total = '0;
        end

        mag = total[SECONDS_W-1:0];
        if (err != ST_OK) begin
            o_seconds = '0;
        end else if (c[0] == CH_MINUS) begin
            o_seconds = ~mag + 18'd1;
        end else begin
            o_seconds = mag;
        end
        o_status = err;
    end

endmodule

// File: src/utc_offset_id_parser.sv
// Top level of the UTC offset parser: stream ports, limit register, result register.
`timescale 1ns / 1ps

// Takes one character of a UTC offset text per cycle ("Z", or a sign followed by
// h, hh, hhmm, hh:mm, hhmmss or hh:mm:ss) and, for the character marked tlast,
// gives one result: a status in tuser and the signed total seconds in tdata.
// Characters are taken every cycle without gaps, including the first character of
// the next text right after a last one. The edge that accepts the last character
// snapshots the text into the frame register; the decode of that frame is then
// captured in the result register once that register is free, and is offered
// from there. The input stalls only when both the frame register and the result
// register are full and the result is not being taken. The user writes the offset
// limit through i_cfg_wr_en only while no text is in flight; nothing enforces it.
module utc_offset_id_parser import uoip_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [LIMIT_W-1:0]   i_cfg_wr_data,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,   // [7:0] char_code
    input  logic                 s_axis_tlast,   // is_last
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [23:0]          m_axis_tdata,   // [17:0] utc_secs, rest zero
    output logic [STATUS_W-1:0]  m_axis_tuser    // [2:0] status
);

    logic [LIMIT_W-1:0]    r_limit;
    t_frame                frame;
    logic                  frame_valid;
    logic                  out_free;
    logic                  in_accept;
    logic [STATUS_W-1:0]   dec_status;
    logic [SECONDS_W-1:0]  dec_seconds;
    logic                  r_out_valid;
    logic [STATUS_W-1:0]   r_out_status;
    logic [SECONDS_W-1:0]  r_out_seconds;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !frame_valid || out_free;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RST;
        end else if (i_cfg_wr_en) begin
            r_limit <= i_cfg_wr_data;
        end
    end

    uoip_collect u_collect (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (in_accept),
        .i_char        (s_axis_tdata),
        .i_last        (s_axis_tlast),
        .i_frame_take  (out_free),
        .o_frame       (frame),
        .o_frame_valid (frame_valid)
    );

    uoip_decode u_decode (
        .i_frame   (frame),
        .i_limit   (r_limit),
        .o_status  (dec_status),
        .o_seconds (dec_seconds)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= frame_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && frame_valid) begin
            r_out_status  <= dec_status;
            r_out_seconds <= dec_seconds;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = {{(24 - SECONDS_W){1'b0}}, r_out_seconds};

endmodule

// File: src/uoip_checker.sv
// Port-level checks for the UTC offset parser, bound to the top level.
`timescale 1ns / 1ps

module uoip_checker import uoip_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [23:0]          m_axis_tdata,
    input logic [STATUS_W-1:0]  m_axis_tuser
);

    // A waiting result is not withdrawn and does not change.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // A failed parse carries zero seconds.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != ST_OK |-> m_axis_tdata == 24'd0)
        else $error("nonzero seconds with error status");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tuser <= ST_RANGE)
        else $error("status code out of range");

    // An accepted offset never exceeds one day in magnitude.
    a_ok_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == ST_OK |->
            ($signed(m_axis_tdata[17:0]) <= 18'sd86399)
            && ($signed(m_axis_tdata[17:0]) >= -18'sd86399))
        else $error("ok offset beyond one day");

    // The input is never held off while the result register is empty.
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

endmodule

bind utc_offset_id_parser uoip_checker u_uoip_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// File: test/tb_utc_offset_id_parser.sv
// Self-checking testbench for the UTC offset parser with a predictor and random stream traffic.
`timescale 1ns / 1ps

module tb_utc_offset_id_parser;
    import uoip_pkg::*;

    localparam int          CLK_PERIOD     = 20;
    localparam int          RESET_CYCLES   = 12;
    localparam int          PHASE_COUNT    = 7;
    localparam int          CHARS_PER_PHASE = 158;
    localparam int          HOLD_CYCLES    = 80;
    localparam int          SETTLE_CYCLES  = 6;
    localparam int          WATCHDOG_LIMIT = 4000;
    localparam logic [7:0]  CH_SLASH       = 8'h2F;
    localparam logic [7:0]  CH_SEMI        = 8'h3B;
    localparam logic [7:0]  CH_SPACE       = 8'h20;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } t_char_item;

    typedef struct packed {
        logic [STATUS_W-1:0]         status;
        logic signed [SECONDS_W-1:0] seconds;
    } t_offset_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_wr_en = 1'b0;
    logic [LIMIT_W-1:0]    i_cfg_wr_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata = '0;   // [7:0] char_code
    logic                  s_axis_tlast = 1'b0; // is_last
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [23:0]           m_axis_tdata;        // [17:0] utc_secs, rest zero
    logic [STATUS_W-1:0]   m_axis_tuser;        // [2:0] status

    t_char_item            pending_chars[$];
    t_offset_result        expected_offsets[$];
    logic [CHAR_W-1:0]     text_buf[$];

    // Predictor state: the text collected so far and the active limit.
    logic [STORE_DEPTH-1:0][CHAR_W-1:0] held_chars = '0;
    int unsigned           held_count = 0;
    logic [LIMIT_W-1:0]    held_limit = LIMIT_RST;

    t_char_item            tx_item;
    bit                    tx_busy = 1'b0;
    bit                    tx_burst = 1'b0;
    int unsigned           tx_wait = 0;
    bit                    rx_burst = 1'b0;
    int unsigned           rx_wait = 0;
    int unsigned           chars_sent = 0;
    int unsigned           results_checked = 0;
    int unsigned           mismatches = 0;
    int unsigned           idle_cycles = 0;
    int unsigned           limits_used = 1;

    utc_offset_id_parser dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    function automatic bit is_numeral(input logic [CHAR_W-1:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // Fault of a two-digit field at position p; an earlier fault is kept.
    function automatic logic [STATUS_W-1:0] pair_fault(
        input logic [STATUS_W-1:0]              prior,
        input logic [STORE_DEPTH-1:0][CHAR_W-1:0] txt,
        input int unsigned                     p,
        input bit                              colon
    );
        if (prior != ST_OK) return prior;
        if (colon && txt[p-1] != CH_COLON) return ST_COLON;
        if (!is_numeral(txt[p]) || !is_numeral(txt[p+1])) return ST_DIGIT;
        return ST_OK;
    endfunction

    function automatic int unsigned pair_value(
        input logic [STORE_DEPTH-1:0][CHAR_W-1:0] txt,
        input int unsigned                     p
    );
        return (int'(txt[p]) - int'(CH_ZERO)) * 10 + (int'(txt[p+1]) - int'(CH_ZERO));
    endfunction

    function automatic t_offset_result decode_offset(
        input logic [STORE_DEPTH-1:0][CHAR_W-1:0] txt,
        input int unsigned                     len,
        input logic [LIMIT_W-1:0]              limit
    );
        t_offset_result      res;
        logic [STATUS_W-1:0] st;
        int unsigned         hh;
        int unsigned         mm;
        int unsigned         ss;
        int unsigned         total;
        int unsigned         cap;
        int                  signed_total;
        bit                  len_ok;
        st = ST_OK;
        hh = 0;
        mm = 0;
        ss = 0;
        len_ok = 1'b1;
        res.status = ST_OK;
        res.seconds = '0;
        if (len == 1 && txt[0] == CH_Z) return res;
        case (len)
            2: begin
                if (!is_numeral(txt[1])) st = ST_DIGIT;
                else hh = int'(txt[1]) - int'(CH_ZERO);
            end
            3: begin
                st = pair_fault(st, txt, 1, 1'b0);
                if (st == ST_OK) hh = pair_value(txt, 1);
            end
            5: begin
                st = pair_fault(st, txt, 1, 1'b0);
                st = pair_fault(st, txt, 3, 1'b0);
                if (st == ST_OK) begin
                    hh = pair_value(txt, 1);
                    mm = pair_value(txt, 3);
                end
            end
            6: begin
                st = pair_fault(st, txt, 1, 1'b0);
                st = pair_fault(st, txt, 4, 1'b1);
                if (st == ST_OK) begin
                    hh = pair_value(txt, 1);
                    mm = pair_value(txt, 4);
                end
            end
            7: begin
                st = pair_fault(st, txt, 1, 1'b0);
                st = pair_fault(st, txt, 3, 1'b0);
                st = pair_fault(st, txt, 5, 1'b0);
                if (st == ST_OK) begin
                    hh = pair_value(txt, 1);
                    mm = pair_value(txt, 3);
                    ss = pair_value(txt, 5);
                end
            end
            9: begin
                st = pair_fault(st, txt, 1, 1'b0);
                st = pair_fault(st, txt, 4, 1'b1);
                st = pair_fault(st, txt, 7, 1'b1);
                if (st == ST_OK) begin
                    hh = pair_value(txt, 1);
                    mm = pair_value(txt, 4);
                    ss = pair_value(txt, 7);
                end
            end
            default: len_ok = 1'b0;
        endcase
        if (st == ST_OK && !len_ok) st = ST_FORMAT;
        if (st == ST_OK && txt[0] != CH_PLUS && txt[0] != CH_MINUS) st = ST_SIGN;
        if (st == ST_OK) begin
            total = hh * 3600 + mm * 60 + ss;
            cap = (limit > LIMIT_CAP) ? LIMIT_CAP : limit;
            if (total > cap) begin
                st = ST_RANGE;
            end else begin
                signed_total = (txt[0] == CH_MINUS) ? -int'(total) : int'(total);
                res.seconds = SECONDS_W'(signed_total);
            end
        end
        res.status = st;
        return res;
    endfunction

    function automatic logic [CHAR_W-1:0] rand_digit(input int unsigned top);
        return CH_ZERO + CHAR_W'($urandom_range(0, top));
    endfunction

    // Characters that sit right next to the valid ones, plus plain random bytes.
    function automatic logic [CHAR_W-1:0] odd_char();
        case ($urandom_range(0, 7))
            0: return CH_SLASH;
            1: return CH_COLON;
            2: return CH_SEMI;
            3: return CH_PLUS;
            4: return CH_MINUS;
            5: return CH_Z;
            6: return CH_SPACE;
            default: return CHAR_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [LIMIT_W-1:0] limit_for_phase(input int k);
        case (k)
            1: return '0;
            2: return LIMIT_CAP;
            3: return '1;
            4: return LIMIT_W'(3600);
            5: return LIMIT_W'($urandom_range(1, 86398));
            default: return LIMIT_RST;
        endcase
    endfunction

    // Mostly well-formed offsets with random digits; the rest corrupted or pure noise.
    task automatic fill_random_text();
        int unsigned pick;
        int unsigned shape;
        int unsigned n;
        int unsigned idx;
        text_buf.delete();
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
            text_buf.push_back(CH_Z);
        end else if (pick < 82) begin
            text_buf.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
            shape = $urandom_range(0, 5);
            if (shape == 0) begin
                text_buf.push_back(rand_digit(9));
            end else begin
                text_buf.push_back(rand_digit(2));
                text_buf.push_back(rand_digit(9));
                if (shape >= 2) begin
                    if (shape == 3 || shape == 5) text_buf.push_back(CH_COLON);
                    text_buf.push_back(rand_digit(($urandom_range(0, 7) == 0) ? 9 : 5));
                    text_buf.push_back(rand_digit(9));
                end
                if (shape >= 4) begin
                    if (shape == 5) text_buf.push_back(CH_COLON);
                    text_buf.push_back(rand_digit(($urandom_range(0, 7) == 0) ? 9 : 5));
                    text_buf.push_back(rand_digit(9));
                end
            end
            if (pick >= 74) begin
                text_buf.push_back(rand_digit(9));
            end else if (pick >= 66) begin
                idx = $urandom_range(0, text_buf.size() - 1);
                text_buf[idx] = odd_char();
            end
        end else begin
            n = $urandom_range(1, 14);
            repeat (n) text_buf.push_back(CHAR_W'($urandom_range(0, 255)));
            if ($urandom_range(0, 1)) text_buf[0] = CH_PLUS;
        end
    endtask

    task automatic queue_text();
        t_char_item item;
        for (int i = 0; i < text_buf.size(); i++) begin
            item.code = text_buf[i];
            item.last = (i == text_buf.size() - 1);
            pending_chars.push_back(item);
        end
    endtask

    task automatic queue_string(input string s);
        text_buf.delete();
        for (int i = 0; i < s.len(); i++) text_buf.push_back(CHAR_W'(s[i]));
        queue_text();
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] value);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic drain();
        while (pending_chars.size() != 0 || tx_busy || expected_offsets.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        int unsigned phase_chars;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int k = 0; k < PHASE_COUNT; k++) begin
            if (k != 0) begin
                write_limit(limit_for_phase(k));
                limits_used++;
            end
            @(negedge i_clk);
            if (k == 0) begin
                // Zulu, one-digit hour, the limit exactly and just past it.
                queue_string("Z");
                queue_string("+7");
                queue_string("-0930");
                queue_string("+18");
                queue_string("-123456");
                queue_string("+18:00:01");
                queue_string("-23:59:59");
            end
            phase_chars = 0;
            while (phase_chars < CHARS_PER_PHASE) begin
                fill_random_text();
                queue_text();
                phase_chars += text_buf.size();
            end
            drain();
        end
        if (expected_offsets.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, expected_offsets.size());
            mismatches++;
        end
        $display("Sent %0d characters under %0d limit settings and checked %0d results.",
                 chars_sent, limits_used, results_checked);
        $display("Mismatches seen: %0d.", mismatches);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Sender: each item waits a random gap, except during bursts.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            tx_busy = 1'b0;
            tx_wait = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                tx_busy = 1'b0;
                chars_sent++;
                if ($urandom_range(0, 63) == 0) tx_burst = ~tx_burst;
            end
            if (!tx_busy && pending_chars.size() != 0) begin
                tx_item = pending_chars.pop_front();
                tx_busy = 1'b1;
                tx_wait = tx_burst ? 0 : $urandom_range(0, 6);
            end
            if (tx_busy && tx_wait == 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= tx_item.code;
                s_axis_tlast <= tx_item.last;
            end else begin
                s_axis_tvalid <= 1'b0;
                if (tx_busy) tx_wait--;
            end
        end
    end

    // Predictor: follows every accepted character and every limit write.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            held_count = 0;
            held_limit = LIMIT_RST;
        end else begin
            if (i_cfg_wr_en) held_limit = i_cfg_wr_data;
            if (s_axis_tvalid && s_axis_tready) begin
                if (held_count < STORE_DEPTH) held_chars[held_count] = s_axis_tdata;
                if (held_count < COUNT_SAT) held_count++;
                if (s_axis_tlast) begin
                    expected_offsets.push_back(decode_offset(held_chars, held_count,
                                                             held_limit));
                    held_count = 0;
                end
            end
        end
    end

    // Receiver: checks each result and stalls at random, twice for a long stretch.
    always @(posedge i_clk) begin
        t_offset_result exp_res;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_wait = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_offsets.size() == 0) begin
                    $display("%0t: unexpected result, status %0d tdata %h", $time,
                             m_axis_tuser, m_axis_tdata);
                    mismatches++;
                end else begin
                    exp_res = expected_offsets.pop_front();
                    if (m_axis_tuser !== exp_res.status) begin
                        $display("%0t: status expected %0d, got %0d", $time,
                                 exp_res.status, m_axis_tuser);
                        mismatches++;
                    end
                    if (m_axis_tdata !== {6'd0, exp_res.seconds}) begin
                        $display("%0t: seconds expected %0d, got %0d (tdata %h)", $time,
                                 exp_res.seconds, $signed(m_axis_tdata[SECONDS_W-1:0]),
                                 m_axis_tdata);
                        mismatches++;
                    end
                end
                results_checked++;
                if ($urandom_range(0, 31) == 0) rx_burst = ~rx_burst;
                if (results_checked == 40 || results_checked == 150) rx_wait = HOLD_CYCLES;
                else rx_wait = rx_burst ? 0 : $urandom_range(0, 6);
            end
            if (rx_wait > 0) begin
                m_axis_tready <= 1'b0;
                rx_wait--;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Ends the run if neither side moves an item for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, idle_cycles);
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
